// ----- design/voltmeter_seven_segment_scan_macros.svh -----
// assertion macros for the voltmeter seven-segment scan block
// included by files that carry concurrent assertions; no other dependencies
`ifndef VOLTMETER_SEVEN_SEGMENT_SCAN_MACROS_SVH
`define VOLTMETER_SEVEN_SEGMENT_SCAN_MACROS_SVH

`ifndef SYNTHESIS
// condition and consequence in the same cycle
`define VSS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// consequence in the cycle after the condition
`define VSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define VSS_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define VSS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- design/vss_pkg.sv -----
// types, constants and the segment table of the voltmeter seven-segment scan block
// no dependencies
`timescale 1ns / 1ps

package vss_pkg;

    // input item: kind and converter reading
    typedef struct packed {
        logic       func;
        logic [9:0] sample;
    } t_in_item;

    // result item: segment pattern and one-hot digit select
    typedef struct packed {
        logic [7:0] segments;
        logic [2:0] digit_enable;
    } t_out_item;

    // item kinds
    localparam logic FUNC_SAMPLE = 1'b0;
    localparam logic FUNC_TICK   = 1'b1;

    // configuration
    localparam logic [13:0] FULL_SCALE_RESET = 14'd5000;
    localparam logic [9:0]  ADC_MAX          = 10'd1023;
    localparam logic [13:0] MV_MAX           = 14'd9999;

    // scan positions
    localparam logic [1:0] SCAN_IDLE   = 2'd0;
    localparam logic [1:0] SCAN_FIRST  = 2'd1;
    localparam logic [1:0] SCAN_SECOND = 2'd2;
    localparam logic [1:0] SCAN_THIRD  = 2'd3;

    // digit selects
    localparam logic [2:0] EN_FIRST  = 3'b001;
    localparam logic [2:0] EN_SECOND = 3'b010;
    localparam logic [2:0] EN_THIRD  = 3'b100;

    localparam logic [7:0] DP_BIT = 8'b1000_0000;

    // reciprocal constants for the decimal digit split (exact for values below 10000)
    localparam logic [15:0] RECIP_10   = 16'd52429;
    localparam int          SHIFT_10   = 19;
    localparam logic [12:0] RECIP_100  = 13'd5243;
    localparam int          SHIFT_100  = 19;
    localparam logic [13:0] RECIP_1000 = 14'd8389;
    localparam int          SHIFT_1000 = 23;

    // seven-segment pattern of a decimal digit, blank for codes above nine
    function automatic logic [7:0] seg_of(input logic [3:0] d);
        logic [7:0] s;
        case (d)
            4'd0:    s = 8'h3F;
            4'd1:    s = 8'h06;
            4'd2:    s = 8'h5B;
            4'd3:    s = 8'h4F;
            4'd4:    s = 8'h66;
            4'd5:    s = 8'h6D;
            4'd6:    s = 8'h7D;
            4'd7:    s = 8'h07;
            4'd8:    s = 8'h7F;
            4'd9:    s = 8'h6F;
            default: s = 8'h00;
        endcase
        return s;
    endfunction

endpackage

// ----- design/vss_stream_if.sv -----
// valid/ready stream channel carrying one payload item
// payload type is set by the instantiating level; no other dependencies
`timescale 1ns / 1ps

interface vss_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- design/voltmeter_seven_segment_scan.sv -----
// top level of the voltmeter seven-segment scan block
// depends on vss_pkg, vss_stream_if and the assertion macro header
`timescale 1ns / 1ps
`include "voltmeter_seven_segment_scan_macros.svh"

// Three-digit voltmeter display driver.
// i_in (sink, vss_pkg::t_in_item): func 0 carries a 10-bit converter sample,
//   func 1 is a display scan tick. Samples give no result.
// o_out (source, vss_pkg::t_out_item): one item per tick with the segment
//   pattern (bit7 decimal point) and the one-hot digit select of the next
//   scan position, cycling first, second, third digit.
// i_cfg_we / i_cfg_wdata: writes full_scale_mv; the reading is scaled to
//   millivolts as sample * full_scale_mv / 1023, saturated at 9999.
// Throughput: one item per cycle unless a stalled receiver holds a tick. Every
// item passes the same five-stage pipe (input, product, quotient estimate,
// millivolts, digit quotients) and then the output register, so a tick result
// always sees the digits of every sample accepted before it.
// Reset (synchronous, active low) empties the pipe, sets full scale to
// 5000 mV and clears the digits and scan position.
// A stalled receiver holds the output register; bubbles and samples still
// move forward, so the input is refused only once the pipe fills behind
// a waiting tick.
module voltmeter_seven_segment_scan (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    vss_stream_if.sink           i_in,
    vss_stream_if.source         o_out,
    input  logic                 i_cfg_we,
    input  logic [13:0]          i_cfg_wdata
);

    // configuration register
    logic [13:0] r_fs;

    // pipeline valid bits and item kinds
    logic r_s0_v, r_s1_v, r_s2_v, r_s3_v, r_s4_v;
    logic r_s0_func, r_s1_func, r_s2_func, r_s3_func, r_s4_func;

    // pipeline payload
    logic [9:0]  r_s0_sample;
    logic [23:0] r_s1_prod;
    logic [23:0] r_s2_prod;
    logic [13:0] r_s2_q0;
    logic [13:0] r_s3_mv;
    logic [9:0]  r_s4_q10;
    logic [6:0]  r_s4_q100;
    logic [3:0]  r_s4_q1000;

    // display state
    logic [1:0] r_scan;
    logic [3:0] r_dig_th, r_dig_hu, r_dig_te;

    // output register
    logic                r_out_valid;
    vss_pkg::t_out_item  r_out_item;

    // stage advance chain
    logic w_rdy_out, w_rdy4, w_rdy3, w_rdy2, w_rdy1, w_rdy0;

    // datapath nets
    logic [23:0] w_prod;
    logic [23:0] w_est_sum;
    logic [23:0] w_rem;
    logic [14:0] w_q;
    logic [13:0] w_mv;
    logic [29:0] w_m10;
    logic [26:0] w_m100;
    logic [27:0] w_m1000;
    logic [13:0] w_tens_full;
    logic [10:0] w_hund_full;
    logic [1:0]  n_scan;
    vss_pkg::t_out_item n_out_item;

    // a stage takes new contents when empty or when its item moves on;
    // samples leave the last stage freely, ticks need room at the output
    always_comb begin
        w_rdy_out = !r_out_valid || o_out.ready;
        w_rdy4    = !r_s4_v || (r_s4_func == vss_pkg::FUNC_SAMPLE) || w_rdy_out;
        w_rdy3    = !r_s3_v || w_rdy4;
        w_rdy2    = !r_s2_v || w_rdy3;
        w_rdy1    = !r_s1_v || w_rdy2;
        w_rdy0    = !r_s0_v || w_rdy1;
    end

    assign i_in.ready    = w_rdy0;
    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out_item;

    // full-scale register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fs <= vss_pkg::FULL_SCALE_RESET;
        end else if (i_cfg_we) begin
            r_fs <= i_cfg_wdata;
        end
    end

    // reading times full scale
    assign w_prod = 24'(r_s0_sample) * 24'(r_fs);

    // quotient estimate by 1023: p/1024 * (1 + 2^-10 + 2^-20), low by at most one
    assign w_est_sum = r_s1_prod + (r_s1_prod >> 10) + (r_s1_prod >> 20);

    // remainder check corrects the estimate, then saturate
    always_comb begin
        w_rem = r_s2_prod + 24'(r_s2_q0) - {r_s2_q0, 10'b0};
        w_q   = 15'(r_s2_q0) + ((w_rem >= 24'(vss_pkg::ADC_MAX)) ? 15'd1 : 15'd0);
        if (w_q > 15'(vss_pkg::MV_MAX)) begin
            w_mv = vss_pkg::MV_MAX;
        end else begin
            w_mv = w_q[13:0];
        end
    end

    // division by 10, 100 and 1000 through reciprocal constants
    always_comb begin
        w_m10   = 30'(r_s3_mv) * 30'(vss_pkg::RECIP_10);
        w_m100  = 27'(r_s3_mv) * 27'(vss_pkg::RECIP_100);
        w_m1000 = 28'(r_s3_mv) * 28'(vss_pkg::RECIP_1000);
    end

    // remaining digits from the quotients
    always_comb begin
        w_tens_full = 14'(r_s4_q10) - 14'(r_s4_q100) * 14'd10;
        w_hund_full = 11'(r_s4_q100) - 11'(r_s4_q1000) * 11'd10;
    end

    // next scan position and the pattern it shows
    always_comb begin
        if (r_scan >= vss_pkg::SCAN_THIRD) begin
            n_scan = vss_pkg::SCAN_FIRST;
        end else begin
            n_scan = r_scan + 2'd1;
        end
        case (n_scan)
            vss_pkg::SCAN_FIRST: begin
                n_out_item.segments     = vss_pkg::seg_of(r_dig_th) | vss_pkg::DP_BIT;
                n_out_item.digit_enable = vss_pkg::EN_FIRST;
            end
            vss_pkg::SCAN_SECOND: begin
                n_out_item.segments     = vss_pkg::seg_of(r_dig_hu);
                n_out_item.digit_enable = vss_pkg::EN_SECOND;
            end
            default: begin
                n_out_item.segments     = vss_pkg::seg_of(r_dig_te);
                n_out_item.digit_enable = vss_pkg::EN_THIRD;
            end
        endcase
    end

    // pipeline valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_v <= 1'b0;
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_s4_v <= 1'b0;
        end else begin
            if (w_rdy0) r_s0_v <= i_in.valid;
            if (w_rdy1) r_s1_v <= r_s0_v;
            if (w_rdy2) r_s2_v <= r_s1_v;
            if (w_rdy3) r_s3_v <= r_s2_v;
            if (w_rdy4) r_s4_v <= r_s3_v;
        end
    end

    // pipeline payload
    always_ff @(posedge i_clk) begin
        if (w_rdy0) begin
            r_s0_func   <= i_in.payload.func;
            r_s0_sample <= i_in.payload.sample;
        end
        if (w_rdy1) begin
            r_s1_func <= r_s0_func;
            r_s1_prod <= w_prod;
        end
        if (w_rdy2) begin
            r_s2_func <= r_s1_func;
            r_s2_prod <= r_s1_prod;
            r_s2_q0   <= w_est_sum[23:10];
        end
        if (w_rdy3) begin
            r_s3_func <= r_s2_func;
            r_s3_mv   <= w_mv;
        end
        if (w_rdy4) begin
            r_s4_func  <= r_s3_func;
            r_s4_q10   <= w_m10[vss_pkg::SHIFT_10 +: 10];
            r_s4_q100  <= w_m100[vss_pkg::SHIFT_100 +: 7];
            r_s4_q1000 <= w_m1000[vss_pkg::SHIFT_1000 +: 4];
        end
    end

    // digit store, updated as a sample leaves the last stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dig_th <= 4'd0;
            r_dig_hu <= 4'd0;
            r_dig_te <= 4'd0;
        end else if (r_s4_v && (r_s4_func == vss_pkg::FUNC_SAMPLE)) begin
            r_dig_th <= r_s4_q1000;
            r_dig_hu <= w_hund_full[3:0];
            r_dig_te <= w_tens_full[3:0];
        end
    end

    // scan position and output register, loaded as a tick leaves the last stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan      <= vss_pkg::SCAN_IDLE;
            r_out_valid <= 1'b0;
        end else if (w_rdy_out) begin
            r_out_valid <= r_s4_v && (r_s4_func == vss_pkg::FUNC_TICK);
            if (r_s4_v && (r_s4_func == vss_pkg::FUNC_TICK)) begin
                r_scan <= n_scan;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_out && r_s4_v && (r_s4_func == vss_pkg::FUNC_TICK)) begin
            r_out_item <= n_out_item;
        end
    end

    // assertions
    `VSS_ASSERT_SAME(a_digits_decimal, i_clk, i_rst_n, 1'b1,
        (r_dig_th <= 4'd9) && (r_dig_hu <= 4'd9) && (r_dig_te <= 4'd9))
    `VSS_ASSERT_SAME(a_out_onehot, i_clk, i_rst_n, r_out_valid,
        $onehot(r_out_item.digit_enable))
    `VSS_ASSERT_SAME(a_dp_first_only, i_clk, i_rst_n, r_out_valid,
        r_out_item.segments[7] == r_out_item.digit_enable[0])
    `VSS_ASSERT_SAME(a_scan_matches_out, i_clk, i_rst_n, r_out_valid,
        (r_scan != vss_pkg::SCAN_IDLE) && (r_out_item.digit_enable[r_scan - 2'd1]))
    `VSS_ASSERT_NEXT(a_sample_no_result, i_clk, i_rst_n,
        w_rdy_out && r_s4_v && (r_s4_func == vss_pkg::FUNC_SAMPLE), !r_out_valid)

endmodule
